// ===== sv/wlvb_pkg.sv =====
// Shared types and constants of the wear-leveled voting byte store.
// Depends on nothing; wlvb_if, wlvb_vote and the top level import it.
`default_nettype none

package wlvb_pkg;

  localparam int unsigned MAX_SLOTS  = 256;
  localparam int unsigned MAX_COPIES = 8;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned BASE_W     = 10;
  localparam int unsigned COPY_W     = 4;
  localparam int unsigned COPY_IDX_W = $clog2(MAX_COPIES);
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // The modulo unit takes one restoring step per cycle.
  localparam int unsigned RED_STEPS = 9;
  localparam int unsigned RED_W     = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_FORMAT  = 2'd0,
    CMD_RECOVER = 2'd1,
    CMD_READ    = 2'd2,
    CMD_WRITE   = 2'd3
  } cmd_e;

  localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_MAJORITY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FORMATTED   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COPIES       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_CODE   = 3'd4;

  localparam logic [CNT_W-1:0]  RST_SLOT_COUNT   = 9'd16;
  localparam logic [BASE_W-1:0] RST_BASE_ADDRESS = 10'd0;
  localparam logic [COPY_W-1:0] RST_COPIES       = 4'd3;
  localparam logic [BYTE_W-1:0] RST_EMPTY_CODE   = 8'd255;
  localparam logic [BYTE_W-1:0] RST_ERROR_CODE   = 8'd254;
  localparam logic [BYTE_W-1:0] ERASED_BYTE      = 8'hFF;

  typedef struct packed {
    logic                  load;
    logic [COPY_IDX_W-1:0] load_idx;
    logic [BYTE_W-1:0]     load_data;
    logic                  start;
    logic [COPY_W-1:0]     copies;
  } vote_ctrl_t;

  typedef struct packed {
    logic              done;
    logic              ok;
    logic [BYTE_W-1:0] value;
  } vote_rsp_t;

endpackage

`default_nettype wire

// ===== sv/wlvb_if.sv =====
// Channel interfaces of the wear-leveled voting byte store: command input,
// result output and configuration write. Depends on wlvb_pkg.
`default_nettype none

interface wlvb_in_if import wlvb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] write_value;
  logic [SLOT_W-1:0] start_slot;

  modport source (output valid, command, write_value, start_slot, input ready);
  modport sink (input valid, command, write_value, start_slot, output ready);
endinterface

interface wlvb_out_if import wlvb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_value;
  logic [SLOT_W-1:0] slot;
  logic [STAT_W-1:0] status;

  modport source (output valid, read_value, slot, status, input ready);
  modport sink (input valid, read_value, slot, status, output ready);
endinterface

interface wlvb_cfg_if import wlvb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/wlvb_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module wlvb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/wlvb_reduce.sv =====
// Shared modulo unit: restoring reduction, one shifted compare-subtract a cycle.
// Depends on nothing; the top level feeds it addresses and slot numbers.
`default_nettype none

module wlvb_reduce #(
  parameter int unsigned VAL_W = 12,
  parameter int unsigned DIV_W = 11,
  parameter int unsigned STEPS = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [VAL_W-1:0] result_o
);

  localparam int unsigned SH_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned CMP_W = (DIV_W + STEPS > VAL_W) ? DIV_W + STEPS : VAL_W;

  logic             busy_q, busy_d;
  logic [VAL_W-1:0] v_q, v_d;
  logic [DIV_W-1:0] d_q, d_d;
  logic [SH_W-1:0]  sh_q, sh_d;
  logic [CMP_W-1:0] cand;
  logic [CMP_W-1:0] v_ext;
  logic [VAL_W-1:0] v_step;

  // The value always stays below divisor << (sh + 1), so after the last
  // step it is below the divisor.
  always_comb begin
    cand   = CMP_W'(d_q) << sh_q;
    v_ext  = CMP_W'(v_q);
    v_step = (v_ext >= cand) ? VAL_W'(v_ext - cand) : v_q;
  end

  assign done_o   = busy_q && (sh_q == '0);
  assign result_o = v_step;

  always_comb begin
    busy_d = busy_q;
    v_d    = v_q;
    d_d    = d_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = value_i;
      d_d    = divisor_i;
      sh_d   = SH_W'(STEPS - 1);
    end else if (busy_q) begin
      v_d  = v_step;
      sh_d = sh_q - SH_W'(1);
      if (sh_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q  <= v_d;
    d_q  <= d_d;
    sh_q <= sh_d;
  end

endmodule

`default_nettype wire

// ===== sv/wlvb_vote.sv =====
// Majority voter: holds the copies of one slot and tests one candidate a cycle.
// Depends on wlvb_pkg for the control and response structs.
`default_nettype none

module wlvb_vote import wlvb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  vote_ctrl_t ctrl_i,
  output vote_rsp_t  rsp_o
);

  logic [BYTE_W-1:0]     cpy_q [MAX_COPIES];
  logic [BYTE_W-1:0]     cpy_d [MAX_COPIES];
  logic [MAX_COPIES-1:0] live_q, live_d;
  logic [COPY_W-1:0]     cop_q, cop_d;
  logic                  busy_q, busy_d;
  logic [COPY_W-1:0]     match_cnt;
  logic [COPY_W-1:0]     need;
  logic                  single;
  logic                  win;
  logic                  lose;
  logic                  fin;

  // The candidate always sits in entry 0; live marks the entries that still hold copies.
  always_comb begin
    match_cnt = '0;
    for (int j = 1; j < MAX_COPIES; j++) begin
      if (live_q[j] && (cpy_q[j] == cpy_q[0])) begin
        match_cnt = match_cnt + COPY_W'(1);
      end
    end
    need   = (cop_q >> 1) + COPY_W'(1);
    single = (cop_q == COPY_W'(1));
    win    = single || (live_q[1] && ((match_cnt + COPY_W'(1)) >= need));
    lose   = !single && !live_q[1];
    fin    = busy_q && (win || lose);
  end

  assign rsp_o.done  = fin;
  assign rsp_o.ok    = win;
  assign rsp_o.value = cpy_q[0];

  always_comb begin
    busy_d = busy_q;
    live_d = live_q;
    cop_d  = cop_q;
    for (int j = 0; j < MAX_COPIES; j++) begin
      cpy_d[j] = cpy_q[j];
      if (busy_q && !fin && (j < MAX_COPIES - 1)) begin
        cpy_d[j] = cpy_q[j+1];
      end
      if (ctrl_i.load && (ctrl_i.load_idx == COPY_IDX_W'(j))) begin
        cpy_d[j] = ctrl_i.load_data;
      end
    end
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cop_d  = ctrl_i.copies;
      for (int j = 0; j < MAX_COPIES; j++) begin
        live_d[j] = (COPY_W'(j) < ctrl_i.copies);
      end
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      live_d = live_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cpy_q  <= cpy_d;
    live_q <= live_d;
    cop_q  <= cop_d;
  end

endmodule

`default_nettype wire

// ===== sv/wear_leveled_voting_byte_store.sv =====
// Wear-leveled voting byte store: top level with the command sequencer.
// Depends on wlvb_pkg, wlvb_if, wlvb_ram, wlvb_reduce and wlvb_vote.
`default_nettype none

// One byte value is kept in a ring of slots inside a single-port byte RAM of
// STORE_BYTES bytes; each slot holds "copies" consecutive copies starting at
// base_address + slot * copies, addresses wrapping at the end of the RAM.
// Every command beat produces exactly one result beat. The block handles one
// command at a time and holds in_i.ready low while it works; a finished result
// waits in an output register, so the next command is taken meanwhile. All
// memory traffic goes through the one RAM port (one byte a cycle); a slot's
// start address computed from base_address and its slot number, and every
// slot number that needs a modulo, go through one shared restoring reduction
// unit, while stepping on to the next slot wraps by a single compare-subtract.
// After reset the block first sweeps the RAM to 0xFF, one byte a cycle, and
// accepts no command during that sweep; configuration writes are taken at any
// time but must only be issued while the block is idle.
module wear_leveled_voting_byte_store import wlvb_pkg::*; #(
  parameter int unsigned STORE_BYTES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wlvb_cfg_if.sink          cfg_i,
  wlvb_in_if.sink           in_i,
  wlvb_out_if.source        out_o
);

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned DIV_W  = ($clog2(STORE_BYTES + 1) > CNT_W) ?
                                   $clog2(STORE_BYTES + 1) : CNT_W;
  localparam int unsigned RVAL_W = (ADDR_W > RED_W) ? ADDR_W : RED_W;
  localparam int unsigned OFF_W  = CNT_W + COPY_W;

  localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [ADDR_W:0]     WRAP_SUM  = (ADDR_W + 1)'(STORE_BYTES);
  localparam logic [DIV_W-1:0]    STORE_DIV = DIV_W'(STORE_BYTES);
  localparam logic [CNT_W-1:0]    SLOT_MAX  = CNT_W'(MAX_SLOTS);
  localparam logic [COPY_W-1:0]   COPY_MAX  = COPY_W'(MAX_COPIES);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_RED   = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_VOTE  = 3'd5;
  localparam logic [2:0] ST_WR    = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Configuration registers.
  logic [CNT_W-1:0]  slot_count_q, slot_count_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [COPY_W-1:0] copies_q, copies_d;
  logic [BYTE_W-1:0] empty_q, empty_d;
  logic [BYTE_W-1:0] error_q, error_d;

  // Control state.
  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0]  wc_q, wc_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [COPY_W-1:0] k_q, k_d;
  logic              rd_pend_q, rd_pend_d;
  logic              fmt_q, fmt_d;
  logic              roll_q, roll_d;
  logic              red_slot_q, red_slot_d;
  logic              ov_q, ov_d;

  // Per-command working values.
  cmd_e              cmd_q, cmd_d;
  logic [BYTE_W-1:0] wv_q, wv_d;
  logic [SLOT_W-1:0] start_q, start_d;
  logic [CNT_W-1:0]  sidx_q, sidx_d;
  logic [ADDR_W-1:0] slot_start_q, slot_start_d;
  logic [BYTE_W-1:0] wdata_q, wdata_d;
  logic [COPY_IDX_W-1:0] cap_idx_q, cap_idx_d;
  logic [BYTE_W-1:0] rv_q, rv_d;
  logic [STAT_W-1:0] st_q, st_d;
  logic [BYTE_W-1:0] orv_q, orv_d;
  logic [SLOT_W-1:0] oslot_q, oslot_d;
  logic [STAT_W-1:0] ost_q, ost_d;

  // Derived values and unit connections.
  logic [CNT_W-1:0]  eff_n;
  logic [COPY_W-1:0] eff_c;
  logic [OFF_W-1:0]  slot_off;
  logic [ADDR_W-1:0] addr_inc;
  logic [ADDR_W:0]   start_sum;
  logic [ADDR_W-1:0] next_start;
  logic [CNT_W-1:0]  sidx_inc;
  logic [CNT_W-1:0]  wc_inc;
  logic [BYTE_W-1:0] voted;
  cmd_e              in_cmd;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  logic              red_start;
  logic [RVAL_W-1:0] red_value;
  logic [DIV_W-1:0]  red_div;
  logic              red_done;
  logic [RVAL_W-1:0] red_res;

  vote_ctrl_t        vote_ctrl;
  vote_rsp_t         vote_rsp;

  wlvb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  wlvb_reduce #(
    .VAL_W (RVAL_W),
    .DIV_W (DIV_W),
    .STEPS (RED_STEPS)
  ) u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (red_start),
    .value_i   (red_value),
    .divisor_i (red_div),
    .done_o    (red_done),
    .result_o  (red_res)
  );

  wlvb_vote u_vote (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (vote_ctrl),
    .rsp_o  (vote_rsp)
  );

  // Out-of-range settings are clamped: zero acts as one, too large acts as
  // the maximum.
  always_comb begin
    if (slot_count_q == '0) begin
      eff_n = CNT_W'(1);
    end else if (slot_count_q > SLOT_MAX) begin
      eff_n = SLOT_MAX;
    end else begin
      eff_n = slot_count_q;
    end
    if (copies_q == '0) begin
      eff_c = COPY_W'(1);
    end else if (copies_q > COPY_MAX) begin
      eff_c = COPY_MAX;
    end else begin
      eff_c = copies_q;
    end
  end

  // Address walking helpers. A slot start is always below STORE_BYTES and
  // the copy count is far smaller, so a single compare-subtract wraps it.
  always_comb begin
    slot_off   = OFF_W'(sidx_q) * OFF_W'(eff_c);
    addr_inc   = (addr_q == LAST_ADDR) ? '0 : addr_q + ADDR_W'(1);
    start_sum  = (ADDR_W + 1)'(slot_start_q) + (ADDR_W + 1)'(eff_c);
    next_start = (start_sum >= WRAP_SUM) ? ADDR_W'(start_sum - WRAP_SUM)
                                         : ADDR_W'(start_sum);
    sidx_inc   = sidx_q + CNT_W'(1);
    wc_inc     = wc_q + CNT_W'(1);
    voted      = vote_rsp.ok ? vote_rsp.value : error_q;
    in_cmd     = cmd_e'(in_i.command);
  end

  // Configuration writes.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    slot_count_d = slot_count_q;
    base_d       = base_q;
    copies_d     = copies_q;
    empty_d      = empty_q;
    error_d      = error_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SLOT_COUNT:   slot_count_d = cfg_i.data[CNT_W-1:0];
        REG_BASE_ADDRESS: base_d       = cfg_i.data[BASE_W-1:0];
        REG_COPIES:       copies_d     = cfg_i.data[COPY_W-1:0];
        REG_EMPTY_CODE:   empty_d      = cfg_i.data[BYTE_W-1:0];
        REG_ERROR_CODE:   error_d      = cfg_i.data[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // Sequencer. Each command computes the start address of the slot it
  // works on (multiply, then reduce modulo STORE_BYTES), then reads the
  // copies into the voter or writes them one byte a cycle.
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    wc_d         = wc_q;
    addr_d       = addr_q;
    k_d          = k_q;
    rd_pend_d    = rd_pend_q;
    fmt_d        = fmt_q;
    roll_d       = roll_q;
    red_slot_d   = red_slot_q;
    cmd_d        = cmd_q;
    wv_d         = wv_q;
    start_d      = start_q;
    sidx_d       = sidx_q;
    slot_start_d = slot_start_q;
    wdata_d      = wdata_q;
    cap_idx_d    = cap_idx_q;
    rv_d         = rv_q;
    st_d         = st_q;
    orv_d        = orv_q;
    oslot_d      = oslot_q;
    ost_d        = ost_q;
    ov_d         = ov_q && !out_o.ready;

    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = wdata_q;

    red_start = 1'b0;
    red_value = RVAL_W'(start_q);
    red_div   = DIV_W'(eff_n);

    vote_ctrl.load      = 1'b0;
    vote_ctrl.load_idx  = cap_idx_q;
    vote_ctrl.load_data = ram_rdata;
    vote_ctrl.start     = 1'b0;
    vote_ctrl.copies    = eff_c;

    case (state_q)
      ST_CLEAR: begin
        // The erase sweep reuses the copy address counter.
        ram_we    = 1'b1;
        ram_wdata = ERASED_BYTE;
        addr_d    = addr_inc;
        if (addr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = in_cmd;
          wv_d    = in_i.write_value;
          start_d = in_i.start_slot;
          rv_d    = '0;
          st_d    = STAT_OK;
          fmt_d   = 1'b0;
          roll_d  = 1'b0;
          case (in_cmd)
            CMD_FORMAT: begin
              fmt_d      = 1'b1;
              wdata_d    = empty_q;
              red_start  = 1'b1;
              red_value  = RVAL_W'(in_i.start_slot);
              red_slot_d = 1'b1;
              state_d    = ST_RED;
            end
            CMD_RECOVER: begin
              sidx_d  = '0;
              state_d = ST_MUL;
            end
            CMD_READ: begin
              sidx_d  = CNT_W'(cur_q);
              state_d = ST_MUL;
            end
            CMD_WRITE: begin
              // Once the count passes slot_count the current slot is
              // emptied and the ring moves on before the value lands.
              if ((wc_inc > slot_count_q) || (wc_inc == '0)) begin
                wc_d    = CNT_W'(1);
                roll_d  = 1'b1;
                wdata_d = empty_q;
              end else begin
                wc_d    = wc_inc;
                wdata_d = in_i.write_value;
              end
              sidx_d  = CNT_W'(cur_q);
              state_d = ST_MUL;
            end
            default: begin
            end
          endcase
        end
      end

      ST_MUL: begin
        red_start  = 1'b1;
        red_value  = RVAL_W'(base_q) + RVAL_W'(slot_off);
        red_div    = STORE_DIV;
        red_slot_d = 1'b0;
        state_d    = ST_RED;
      end

      ST_RED: begin
        if (red_done) begin
          if (red_slot_q) begin
            cur_d   = red_res[SLOT_W-1:0];
            sidx_d  = fmt_q ? '0 : CNT_W'(red_res[SLOT_W-1:0]);
            state_d = ST_MUL;
          end else begin
            slot_start_d = red_res[ADDR_W-1:0];
            addr_d       = red_res[ADDR_W-1:0];
            k_d          = '0;
            rd_pend_d    = 1'b0;
            if (fmt_q || (cmd_q == CMD_WRITE)) begin
              state_d = ST_WR;
            end else begin
              state_d = ST_RD;
            end
          end
        end
      end

      ST_RD: begin
        // Reads are issued back to back; each byte is caught into the voter in the
        // cycle after its read.
        if (k_q < eff_c) begin
          addr_d    = addr_inc;
          k_d       = k_q + COPY_W'(1);
          rd_pend_d = 1'b1;
          cap_idx_d = k_q[COPY_IDX_W-1:0];
        end else begin
          rd_pend_d = 1'b0;
        end
        if (rd_pend_q) begin
          vote_ctrl.load = 1'b1;
          if (k_q == eff_c) begin
            vote_ctrl.start = 1'b1;
            state_d         = ST_VOTE;
          end
        end
      end

      ST_VOTE: begin
        if (vote_rsp.done) begin
          if (cmd_q == CMD_READ) begin
            rv_d    = voted;
            st_d    = vote_rsp.ok ? STAT_OK : STAT_NO_MAJORITY;
            state_d = ST_DONE;
          end else if (voted != empty_q) begin
            cur_d   = sidx_q[SLOT_W-1:0];
            state_d = ST_DONE;
          end else if (sidx_inc == eff_n) begin
            // Every slot reads empty: format from the given start slot.
            fmt_d      = 1'b1;
            st_d       = STAT_FORMATTED;
            wdata_d    = empty_q;
            red_start  = 1'b1;
            red_slot_d = 1'b1;
            state_d    = ST_RED;
          end else begin
            sidx_d       = sidx_inc;
            slot_start_d = next_start;
            addr_d       = next_start;
            k_d          = '0;
            rd_pend_d    = 1'b0;
            state_d      = ST_RD;
          end
        end
      end

      ST_WR: begin
        ram_we = 1'b1;
        addr_d = addr_inc;
        k_d    = k_q + COPY_W'(1);
        if (k_q == (eff_c - COPY_W'(1))) begin
          if (fmt_q) begin
            if (sidx_inc == eff_n) begin
              state_d = ST_DONE;
            end else begin
              sidx_d       = sidx_inc;
              slot_start_d = next_start;
              addr_d       = next_start;
              k_d          = '0;
            end
          end else if (roll_q) begin
            roll_d     = 1'b0;
            wdata_d    = wv_q;
            red_start  = 1'b1;
            red_value  = RVAL_W'(cur_q) + RVAL_W'(1);
            red_slot_d = 1'b1;
            state_d    = ST_RED;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          orv_d   = rv_q;
          oslot_d = cur_q;
          ost_d   = st_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_o.valid      = ov_q;
  assign out_o.read_value = orv_q;
  assign out_o.slot       = oslot_q;
  assign out_o.status     = ost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      slot_count_q <= RST_SLOT_COUNT;
      base_q       <= RST_BASE_ADDRESS;
      copies_q     <= RST_COPIES;
      empty_q      <= RST_EMPTY_CODE;
      error_q      <= RST_ERROR_CODE;
      cur_q        <= '0;
      wc_q         <= '0;
      addr_q       <= '0;
      k_q          <= '0;
      rd_pend_q    <= 1'b0;
      fmt_q        <= 1'b0;
      roll_q       <= 1'b0;
      red_slot_q   <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_count_q <= slot_count_d;
      base_q       <= base_d;
      copies_q     <= copies_d;
      empty_q      <= empty_d;
      error_q      <= error_d;
      cur_q        <= cur_d;
      wc_q         <= wc_d;
      addr_q       <= addr_d;
      k_q          <= k_d;
      rd_pend_q    <= rd_pend_d;
      fmt_q        <= fmt_d;
      roll_q       <= roll_d;
      red_slot_q   <= red_slot_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    wv_q         <= wv_d;
    start_q      <= start_d;
    sidx_q       <= sidx_d;
    slot_start_q <= slot_start_d;
    wdata_q      <= wdata_d;
    cap_idx_q    <= cap_idx_d;
    rv_q         <= rv_d;
    st_q         <= st_d;
    orv_q        <= orv_d;
    oslot_q      <= oslot_d;
    ost_q        <= ost_d;
  end

`ifndef SYNTH
  // The modulo unit only finishes while the sequencer waits for it.
  a_red_done_in_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |-> (state_q == ST_RED))
    else $error("modulo result outside the reduce state");

  // The voter only finishes while the sequencer waits for it.
  a_vote_done_in_vote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vote_rsp.done |-> (state_q == ST_VOTE))
    else $error("vote result outside the vote state");

  // The RAM is never written while the block is idle or holding a result.
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) || (state_q == ST_DONE)) |-> !ram_we)
    else $error("RAM write outside a command");

  // An accepted write always leaves a nonzero write count.
  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) && in_i.valid && (in_i.command == CMD_WRITE))
      |=> (wc_q != '0))
    else $error("write count is zero after a write");
`endif

endmodule

`default_nettype wire
